// ===== hw/rtl/tlg_pkg.sv =====
// Shared types, constants and functions for the toroidal life grid engine.
// No dependencies; the other files except tlg_ram take items from here by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 32;
    localparam int ROW_W       = $clog2(GRID_HEIGHT);
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int ROWCNT_W    = ROW_W + 1;

    // B3/S23 neighbour counts
    localparam logic [3:0] LIFE_BIRTH   = 4'd3;
    localparam logic [3:0] LIFE_SURVIVE = 4'd2;

    typedef logic [GRID_WIDTH-1:0] row_t;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  col;
        logic [4:0]  row;
        logic        alive;
    } in_item_t;

    typedef struct packed {
        logic [63:0] row_bits;
        logic [31:0] generation;
    } out_item_t;

    typedef enum logic [1:0] {
        RD_SRC_CMD   = 2'd0,
        RD_SRC_LAST  = 2'd1,
        RD_SRC_SWEEP = 2'd2
    } rd_src_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch_cmd;
        logic    clear_all;
        logic    rd_issue;
        rd_src_t rd_src;
        logic    sweep_reset;
        logic    shift_win;
        logic    save_row0;
        logic    wr_sweep;
        logic    wr_last;
        logic    bump_gen;
        logic    load_result;
        logic    push;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rd_pending;
        logic sweep_end;
    } ctrl_status_t;

    // row field modulo GRID_HEIGHT; constant table folded at elaboration
    function automatic logic [ROW_W-1:0] wrap_row(input logic [4:0] r);
        logic [ROW_W-1:0] acc;
        logic [ROW_W-1:0] res;
        acc = '0;
        res = '0;
        for (int i = 0; i < 32; i++) begin
            if (r == 5'(i)) res = acc;
            if (acc == ROW_W'(GRID_HEIGHT - 1)) acc = '0;
            else acc = acc + 1'b1;
        end
        return res;
    endfunction

    // column field modulo GRID_WIDTH
    function automatic logic [COL_W-1:0] wrap_col(input logic [5:0] c);
        logic [COL_W-1:0] acc;
        logic [COL_W-1:0] res;
        acc = '0;
        res = '0;
        for (int i = 0; i < 64; i++) begin
            if (c == 6'(i)) res = acc;
            if (acc == COL_W'(GRID_WIDTH - 1)) acc = '0;
            else acc = acc + 1'b1;
        end
        return res;
    endfunction

    // next generation of one row from its window; columns wrap
    function automatic row_t life_row(input row_t up, input row_t cur, input row_t dn);
        row_t       up_l, up_r, cur_l, cur_r, dn_l, dn_r;
        row_t       res;
        logic [3:0] n;
        up_l  = {up[GRID_WIDTH-2:0], up[GRID_WIDTH-1]};
        up_r  = {up[0], up[GRID_WIDTH-1:1]};
        cur_l = {cur[GRID_WIDTH-2:0], cur[GRID_WIDTH-1]};
        cur_r = {cur[0], cur[GRID_WIDTH-1:1]};
        dn_l  = {dn[GRID_WIDTH-2:0], dn[GRID_WIDTH-1]};
        dn_r  = {dn[0], dn[GRID_WIDTH-1:1]};
        res   = '0;
        for (int x = 0; x < GRID_WIDTH; x++) begin
            n = {3'b000, up_l[x]} + {3'b000, up[x]} + {3'b000, up_r[x]}
              + {3'b000, cur_l[x]} + {3'b000, cur_r[x]}
              + {3'b000, dn_l[x]} + {3'b000, dn[x]} + {3'b000, dn_r[x]};
            res[x] = (n == LIFE_BIRTH) || (cur[x] && (n == LIFE_SURVIVE));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlg_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlg_ctrl.sv =====
// Command sequencer for the life grid engine: one-hot state machine and output valid.
// Depends on tlg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlg_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tlg_pkg::action_t      s_action,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire tlg_pkg::ctrl_status_t status,
    output tlg_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_CLEAR     = 9'b000000010,
        ST_ADV_WRAP  = 9'b000000100,
        ST_ADV_PRIME = 9'b000001000,
        ST_ADV_FIRST = 9'b000010000,
        ST_ADV_SWEEP = 9'b000100000,
        ST_ADV_LAST  = 9'b001000000,
        ST_FETCH     = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    // load_reg marks the first DONE cycle, when the fetched row is captured
    state_t state_reg, state_next;
    logic   load_reg, load_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        load_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_cmd = 1'b1;
                    case (s_action)
                        tlg_pkg::ACT_ADVANCE: state_next = ST_ADV_WRAP;
                        tlg_pkg::ACT_CLEAR:   state_next = ST_CLEAR;
                        default:              state_next = ST_FETCH;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clear_all = 1'b1;
                state_next    = ST_FETCH;
            end
            ST_ADV_WRAP: begin
                cmd.rd_issue    = 1'b1;
                cmd.rd_src      = tlg_pkg::RD_SRC_LAST;
                cmd.sweep_reset = 1'b1;
                state_next      = ST_ADV_PRIME;
            end
            ST_ADV_PRIME: begin
                cmd.rd_issue  = 1'b1;
                cmd.rd_src    = tlg_pkg::RD_SRC_SWEEP;
                cmd.shift_win = 1'b1;
                state_next    = ST_ADV_FIRST;
            end
            ST_ADV_FIRST: begin
                cmd.rd_issue  = 1'b1;
                cmd.rd_src    = tlg_pkg::RD_SRC_SWEEP;
                cmd.shift_win = 1'b1;
                cmd.save_row0 = 1'b1;
                state_next    = ST_ADV_SWEEP;
            end
            ST_ADV_SWEEP: begin
                cmd.rd_issue  = status.rd_pending;
                cmd.rd_src    = tlg_pkg::RD_SRC_SWEEP;
                cmd.shift_win = 1'b1;
                cmd.wr_sweep  = 1'b1;
                if (status.sweep_end) begin
                    state_next = ST_ADV_LAST;
                end
            end
            ST_ADV_LAST: begin
                cmd.wr_last  = 1'b1;
                cmd.bump_gen = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_src   = tlg_pkg::RD_SRC_CMD;
                load_next    = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // first cycle here captures the row, later cycles wait for the output slot
                cmd.load_result = load_reg;
                if (!load_reg && (!out_valid_reg || m_ready)) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            load_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            load_reg      <= load_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_last_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV_LAST) |-> $past(state_reg == ST_ADV_SWEEP))
        else $error("last row written without a sweep");

    a_push_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> out_valid_reg)
        else $error("result transfer lost");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tlg_datapath.sv =====
// Datapath of the life grid engine: row store, row valid bits, three-row window,
// generation counter and result register. Depends on tlg_pkg and tlg_ram.
`timescale 1ns / 1ps
`default_nettype none

module tlg_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tlg_pkg::in_item_t     s_payload,
    input  wire tlg_pkg::ctrl_cmd_t    cmd,
    output tlg_pkg::ctrl_status_t      status,
    output tlg_pkg::out_item_t         m_payload
);

    tlg_pkg::action_t              act_reg;
    logic [tlg_pkg::ROW_W-1:0]     row_idx_reg;
    logic [tlg_pkg::COL_W-1:0]     col_idx_reg;
    logic                          alive_reg;
    logic [tlg_pkg::ROWCNT_W-1:0]  rd_idx_reg;
    logic [tlg_pkg::ROW_W-1:0]     wr_idx_reg;
    logic [tlg_pkg::GRID_HEIGHT-1:0] valid_reg;
    logic                          rd_valid_reg;
    logic [31:0]                   gen_reg;
    tlg_pkg::row_t                 up_reg, cur_reg, row0_reg, res_row_reg;
    tlg_pkg::out_item_t            out_reg;

    logic [tlg_pkg::ROW_W-1:0]     rd_addr, wr_addr;
    logic                          we;
    tlg_pkg::row_t                 rd_data, rd_row, dn_row, life_next, cell_row, wr_data;
    tlg_pkg::row_t                 cell_mask;

    always_comb begin
        case (cmd.rd_src)
            tlg_pkg::RD_SRC_LAST:  rd_addr = tlg_pkg::ROW_W'(tlg_pkg::GRID_HEIGHT - 1);
            tlg_pkg::RD_SRC_SWEEP: rd_addr = rd_idx_reg[tlg_pkg::ROW_W-1:0];
            default:               rd_addr = row_idx_reg;
        endcase
    end

    // rows never written since reset or clear read as dead
    assign rd_row    = rd_valid_reg ? rd_data : '0;
    assign dn_row    = cmd.wr_last ? row0_reg : rd_row;
    assign life_next = tlg_pkg::life_row(up_reg, cur_reg, dn_row);
    assign cell_mask = tlg_pkg::row_t'(1) << col_idx_reg;
    assign cell_row  = alive_reg ? (rd_row | cell_mask) : (rd_row & ~cell_mask);

    assign we      = cmd.wr_sweep || cmd.wr_last ||
                     (cmd.load_result && (act_reg == tlg_pkg::ACT_WRITE));
    assign wr_addr = cmd.load_result ? row_idx_reg : wr_idx_reg;
    assign wr_data = cmd.load_result ? cell_row : life_next;

    tlg_ram #(
        .WIDTH (tlg_pkg::GRID_WIDTH),
        .DEPTH (tlg_pkg::GRID_HEIGHT)
    ) u_rows (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            gen_reg    <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end else begin
            if (cmd.clear_all) begin
                valid_reg <= '0;
            end else if (we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.bump_gen) begin
                gen_reg <= gen_reg + 32'd1;
            end
            if (cmd.sweep_reset) begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
            end else begin
                if (cmd.rd_issue && (cmd.rd_src == tlg_pkg::RD_SRC_SWEEP)) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (cmd.wr_sweep) begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_cmd) begin
            act_reg     <= s_payload.action;
            row_idx_reg <= tlg_pkg::wrap_row(s_payload.row);
            col_idx_reg <= tlg_pkg::wrap_col(s_payload.col);
            alive_reg   <= s_payload.alive;
        end
        if (cmd.rd_issue) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.shift_win) begin
            up_reg  <= cur_reg;
            cur_reg <= rd_row;
        end
        if (cmd.save_row0) begin
            row0_reg <= rd_row;
        end
        if (cmd.load_result) begin
            res_row_reg <= (act_reg == tlg_pkg::ACT_WRITE) ? cell_row : rd_row;
        end
        if (cmd.push) begin
            out_reg.row_bits   <= 64'(res_row_reg);
            out_reg.generation <= gen_reg;
        end
    end

    assign status.rd_pending = (rd_idx_reg < tlg_pkg::ROWCNT_W'(tlg_pkg::GRID_HEIGHT));
    assign status.sweep_end  = (wr_idx_reg == tlg_pkg::ROW_W'(tlg_pkg::GRID_HEIGHT - 2));
    assign m_payload         = out_reg;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && cmd.rd_issue) |-> (wr_addr != rd_addr))
        else $error("row store read and write hit the same row");

    a_last_row_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_last |-> (wr_idx_reg == tlg_pkg::ROW_W'(tlg_pkg::GRID_HEIGHT - 1)))
        else $error("wrap row written at wrong index");

    a_gen_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bump_gen |=> (gen_reg == $past(gen_reg) + 32'd1))
        else $error("generation count did not step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/toroidal_life_grid_engine.sv =====
// Top level of the toroidal life grid engine: sequencer plus datapath.
// Depends on tlg_pkg, tlg_ctrl, tlg_datapath (and tlg_ram below it).
//
// Usage:
//   s_valid/s_ready/s_payload carry one command per transfer: write a cell,
//   read a row, advance one B3/S23 generation on the torus, or clear the grid.
//   col and row are taken modulo the grid size.
//   m_valid/m_ready/m_payload return exactly one result per command: the
//   addressed row after the command and the wrapping generation count.
// Sequencing:
//   commands run one at a time; the next is taken once the result of the last
//   has been loaded and pushed to the output register. Advance runs a
//   one-row-a-cycle sweep, which writes each new row two rows behind the row
//   it reads.
// Reset (aresetn low, synchronous): all cells dead, generation zero, no result
//   pending. Rows carry valid bits, so reset and clear take effect at once.
// Stall: the result sits in an output register; a new command is taken while
//   it waits, and that command finishes but holds in its last state until
//   the pending result has been transferred.
`timescale 1ns / 1ps
`default_nettype none

module toroidal_life_grid_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tlg_pkg::in_item_t  s_payload,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tlg_pkg::out_item_t      m_payload
);

    tlg_pkg::ctrl_cmd_t    cmd;
    tlg_pkg::ctrl_status_t status;

    // sequencer: decides per cycle which datapath operations run
    tlg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_payload.action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // grid store, life window and result register
    tlg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire
